// ===== src/base32_stream_encoder_macros.svh =====
// Assertion macros shared by the Base32 stream encoder modules.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define B32E_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("b32e assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define B32E_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("b32e assertion failed");
`else
`define B32E_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define B32E_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== src/b32e_pkg.sv =====
// Package with types, constants and tables of the Base32 stream encoder.
package b32e_pkg;

    localparam int GroupChars = 8;
    localparam int GroupBits = 40;
    localparam int ChunkBits = 5;
    localparam int QueueDepthDefault = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam logic [2:0] HELD_FULL = 3'd4;
    localparam logic [2:0] LAST_SLOT = 3'd7;

    // One complete group handed from the front part to the back part.
    typedef struct packed {
        logic [GroupBits-1:0] bits;
        logic [3:0]           first_pad;
        logic                 msg_last;
    } grp_entry_t;

    // Character slot at which padding starts, by bytes in the group (1..5).
    // Eight means no padding.
    function automatic logic [3:0] first_pad_slot(input logic [2:0] n);
        logic [3:0] slot;
        unique case (n)
            3'd1:    slot = 4'd2;
            3'd2:    slot = 4'd4;
            3'd3:    slot = 4'd5;
            3'd4:    slot = 4'd7;
            default: slot = 4'd8;
        endcase
        return slot;
    endfunction

    // Standard alphabet: A-Z for 0..25, then 2-7.
    function automatic logic [6:0] b32_char(input logic [4:0] idx);
        logic [6:0] ch;
        if (idx < 5'd26)
        begin
            ch = 7'h41 + {2'b00, idx};
        end
        else
        begin
            ch = 7'h32 + {2'b00, idx - 5'd26};
        end
        return ch;
    endfunction

endpackage

// ===== src/b32e_stream_if.sv =====
// Handshake interfaces for the byte input channel and the character output channel.
interface b32e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface b32e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;
    logic       msg_end;

    modport source (output valid, output out_char, output last_char, output msg_end,
                    input ready);
    modport sink (input valid, input out_char, input last_char, input msg_end,
                  output ready);
endinterface

// ===== src/base32_stream_encoder.sv =====
// A byte that closes a group is written into the group queue, then loaded into the back part's
// shift register, from which its first character is shown. Throughput: one character per cycle
// while the receiver is ready; bytes are taken one per cycle while the group queue has room.
// A one-byte message occupies the character serializer for all eight slots of its group.
// Reset (rst_n low, asynchronous) empties the queue, drops the open group and idles the output.
module base32_stream_encoder #(
    parameter int QUEUE_DEPTH = b32e_pkg::QueueDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    b32e_byte_if.sink   byte_chan,
    b32e_char_if.source char_chan
);
    import b32e_pkg::*;

    // Complete groups leave the front part as one request each and wait in the queue,
    // so the front keeps taking bytes while the back part is still emitting characters.
    grp_entry_t push_entry;
    grp_entry_t head;
    logic       push_valid;
    logic       queue_full;
    logic       queue_not_empty;
    logic       pop;

    // The front part stores bytes into the open group and decides, per byte, whether
    // the group closes (fifth byte or end of message) and how many pads it needs.
    b32e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_chan.valid),
        .in_ready   (byte_chan.ready),
        .byte_in    (byte_chan.byte_in),
        .last_byte  (byte_chan.last_byte),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    b32e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    // The back part holds the group in a shift register and walks it five bits at a
    // time, most significant chunk first. It loads the next group on the same edge as
    // the eighth character is taken, so consecutive groups leave without a gap.
    b32e_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (char_chan.valid),
        .out_ready       (char_chan.ready),
        .out_char        (char_chan.out_char),
        .last_char       (char_chan.last_char),
        .msg_end         (char_chan.msg_end)
    );

endmodule

// ===== src/b32e_front.sv =====
// Front part: gathers bytes into groups and classifies each request as store or emit.
module b32e_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_in,
    input  logic                last_byte,
    output logic                push_valid,
    output b32e_pkg::grp_entry_t push_entry,
    input  logic                queue_full
);
    import b32e_pkg::*;

    logic [31:0] group_reg;
    logic [31:0] group_next;
    logic [2:0]  held_reg;
    logic [2:0]  held_next;
    logic [31:0] merged;
    logic [2:0]  n_bytes;
    logic        is_fifth;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept = in_valid && in_ready;
    assign is_fifth = (held_reg >= HELD_FULL);

    // Place the new byte into its lane of the open group.
    always_comb
    begin
        merged = group_reg;
        unique case (held_reg[1:0])
            2'd0: merged[31:24] = byte_in;
            2'd1: merged[23:16] = byte_in;
            2'd2: merged[15:8]  = byte_in;
            2'd3: merged[7:0]   = byte_in;
        endcase
    end

    assign n_bytes = is_fifth ? 3'd5 : held_reg + 3'd1;

    assign push_valid = accept && (is_fifth || last_byte);
    assign push_entry.bits = is_fifth ? {group_reg, byte_in} : {merged, 8'h00};
    assign push_entry.first_pad = first_pad_slot(n_bytes);
    assign push_entry.msg_last = last_byte;

    always_comb
    begin
        group_next = group_reg;
        held_next = held_reg;
        if (push_valid)
        begin
            group_next = '0;
            held_next = '0;
        end
        else if (accept)
        begin
            group_next = merged;
            held_next = n_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            held_reg <= '0;
        end
        else
        begin
            group_reg <= group_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/b32e_queue.sv =====
// Short queue of complete groups between the front and back parts.
`include "base32_stream_encoder_macros.svh"
module b32e_queue #(
    parameter int DEPTH = b32e_pkg::QueueDepthDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  b32e_pkg::grp_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output b32e_pkg::grp_entry_t head
);
    import b32e_pkg::*;

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
    localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

    grp_entry_t         slots_reg [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_next;
    logic [CntBits-1:0] count_reg;
    logic [CntBits-1:0] count_next;
    logic               do_pop;

    assign full = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign head = slots_reg[rd_ptr_reg];
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `B32E_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push_valid, !full)
    `B32E_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= FullCnt)
    `B32E_ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, !not_empty, wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== src/b32e_back.sv =====
// Back part: serializes one group into eight characters, one per cycle while the receiver is ready.
`include "base32_stream_encoder_macros.svh"
module b32e_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_not_empty,
    input  b32e_pkg::grp_entry_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           out_char,
    output logic                 last_char,
    output logic                 msg_end
);
    import b32e_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [2:0]           slot_reg;
    logic [2:0]           slot_next;
    logic [GroupBits-1:0] shift_reg;
    logic [GroupBits-1:0] shift_next;
    logic [3:0]           first_pad_reg;
    logic [3:0]           first_pad_next;
    logic                 msg_last_reg;
    logic                 msg_last_next;
    logic                 out_accept;
    logic                 group_done;

    assign out_valid = busy_reg;
    assign out_accept = busy_reg && out_ready;
    assign group_done = out_accept && (slot_reg == LAST_SLOT);
    assign pop = queue_not_empty && (!busy_reg || group_done);

    assign out_char = ({1'b0, slot_reg} >= first_pad_reg) ? PAD_CHAR
                    : b32_char(shift_reg[GroupBits-1 -: ChunkBits]);
    assign last_char = (slot_reg == LAST_SLOT);
    assign msg_end = msg_last_reg && (slot_reg == LAST_SLOT);

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        shift_next = shift_reg;
        first_pad_next = first_pad_reg;
        msg_last_next = msg_last_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            slot_next = '0;
            shift_next = head.bits;
            first_pad_next = head.first_pad;
            msg_last_next = head.msg_last;
        end
        else if (group_done)
        begin
            busy_next = 1'b0;
        end
        else if (out_accept)
        begin
            slot_next = slot_reg + 3'd1;
            shift_next = {shift_reg[GroupBits-ChunkBits-1:0], {ChunkBits{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        first_pad_reg <= first_pad_next;
        msg_last_reg <= msg_last_next;
    end

    `B32E_ASSERT_IMPLIES(a_end_on_last, clk, rst_n, busy_reg && msg_end, last_char)
    `B32E_ASSERT_NEXT(a_pad_runs_out, clk, rst_n,
        out_accept && (out_char == PAD_CHAR) && (slot_reg != LAST_SLOT),
        busy_reg && (out_char == PAD_CHAR))
    `B32E_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, busy_reg && !out_ready,
        busy_reg && $stable(slot_reg))

endmodule

// ===== dv/base32_stream_encoder_checker.sv =====
// Checker for the Base32 stream encoder: predicts characters from accepted bytes and compares.
`timescale 1ns / 100ps

module base32_stream_encoder_checker (
    input  logic clk,
    input  logic rst_n,
    b32e_byte_if byte_mon,
    b32e_char_if char_mon,
    output int   fail_count,
    output int   pending,
    output int   chars_checked,
    output int   msgs_closed
);

    import b32e_pkg::*;

    // Standard alphabet, character for index 0 in the top byte.
    localparam logic [8*32-1:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef struct packed {
        logic [6:0] ch;
        logic       last_char;
        logic       msg_end;
    } char_exp_t;

    char_exp_t   char_fifo[$];
    logic [31:0] open_group;
    logic [2:0]  open_count;
    int          fails;
    int          checked;
    int          closed;

    // Adds one byte to the open group and queues the eight characters of a closed group.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        int        held;
        int        n;
        int        pads;
        logic [7:0] fifth;
        logic [39:0] grp;
        logic [4:0] idx;
        char_exp_t  c;
        held = int'(open_count);
        fifth = 8'h00;
        if (held >= 4)
        begin
            fifth = b;
            n = 5;
        end
        else
        begin
            open_group = open_group | ({24'h0, b} << ((3 - held) * 8));
            n = held + 1;
        end
        if (n < 5 && !last)
        begin
            open_count = 3'(n);
            return;
        end
        grp = {open_group, fifth};
        case (n)
            1:       pads = 6;
            2:       pads = 4;
            3:       pads = 3;
            4:       pads = 1;
            default: pads = 0;
        endcase
        for (int k = 0; k < 8; k++)
        begin
            idx = grp[35 - 5 * k +: 5];
            c.ch = (k >= 8 - pads) ? PAD_CHAR : B32_ALPHABET[8 * (31 - int'(idx)) +: 7];
            c.last_char = (k == 7);
            c.msg_end = (k == 7) && last;
            char_fifo.push_back(c);
        end
        open_group = 32'h0;
        open_count = 3'd0;
        if (last)
        begin
            closed++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        char_exp_t want;
        if (!rst_n)
        begin
            char_fifo.delete();
            open_group = 32'h0;
            open_count = 3'd0;
            fails = 0;
            checked = 0;
            closed = 0;
            fail_count <= 0;
            pending <= 0;
            chars_checked <= 0;
            msgs_closed <= 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
            begin
                predict_byte(byte_mon.byte_in, byte_mon.last_byte);
            end
            if (char_mon.valid && char_mon.ready)
            begin
                if (char_fifo.size() == 0)
                begin
                    $error("unexpected character 0x%02h with nothing outstanding",
                           char_mon.out_char);
                    fails++;
                end
                else
                begin
                    want = char_fifo.pop_front();
                    checked++;
                    if (char_mon.out_char !== want.ch)
                    begin
                        $error("out_char: expected 0x%02h, got 0x%02h",
                               want.ch, char_mon.out_char);
                        fails++;
                    end
                    if (char_mon.last_char !== want.last_char)
                    begin
                        $error("last_char: expected %0b, got %0b",
                               want.last_char, char_mon.last_char);
                        fails++;
                    end
                    if (char_mon.msg_end !== want.msg_end)
                    begin
                        $error("msg_end: expected %0b, got %0b",
                               want.msg_end, char_mon.msg_end);
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            pending <= char_fifo.size();
            chars_checked <= checked;
            msgs_closed <= closed;
        end
    end

endmodule

// ===== dv/base32_stream_encoder_tb.sv =====
// Top of the Base32 stream encoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module base32_stream_encoder_tb;

    // Receiver hold-off used to back the block up until it stalls its input.
    localparam int HOLD_CYCLES = 300;
    // Extra cycles waited after every expected character has been checked, before the verdict.
    localparam int DRAIN_CYCLES = 24;
    // Hard stop for the whole run; far above the slowest legal run.
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int ITEMS_PER_PHASE = 105;

    // Directed messages: one byte of zeros, one byte of ones, then messages of two to six
    // bytes, so every pad count shows up, a full group closes a message, and a full group
    // closes without ending the message.
    localparam int DIRECTED_COUNT = 22;
    localparam int DIRECTED_MSGS = 7;
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
        8'h00,
        8'hFF,
        8'hFF, 8'h00,
        8'hAA, 8'h55, 8'hFF,
        8'h00, 8'hFF, 8'hAA, 8'h55,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h80
    };
    localparam int DIRECTED_LENS [DIRECTED_MSGS] = '{1, 1, 2, 3, 4, 5, 6};

    logic clk = 1'b0;
    logic rst_n;

    b32e_byte_if byte_chan ();
    b32e_char_if char_chan ();

    int source_idle_pct;
    int sink_idle_pct;
    int holds_asked;
    int holds_done;
    int bytes_sent;
    int msgs_sent;

    int fail_count;
    int pending;
    int chars_checked;
    int msgs_closed;

    base32_stream_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .char_chan (char_chan)
    );

    base32_stream_encoder_checker char_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_mon      (byte_chan),
        .char_mon      (char_chan),
        .fail_count    (fail_count),
        .pending       (pending),
        .chars_checked (chars_checked),
        .msgs_closed   (msgs_closed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one byte request and returns in the time step of the edge that accepts it.
    // It must be called in the time step of a rising edge. Idle cycles come before the
    // request, so back-to-back requests keep valid high without a glitch.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < source_idle_pct)
        begin
            byte_chan.valid <= 1'b0;
            @(posedge clk);
        end
        byte_chan.valid     <= 1'b1;
        byte_chan.byte_in   <= b;
        byte_chan.last_byte <= last;
        @(posedge clk);
        while (!byte_chan.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Sends a whole message of random bytes; only its final byte carries the end flag.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
        msgs_sent++;
    endtask

    // Message lengths: mostly short so that every pad count is common, now and then long
    // enough to run many full groups back to back.
    function automatic int pick_length();
        int len;
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(40, 13);
        end
        else
        begin
            len = $urandom_range(12, 1);
        end
        return len;
    endfunction

    // Receiver: ready is redrawn every cycle from the current idle rate. When a hold-off
    // is asked for, ready stays low for a counted stretch so the group queue fills up.
    initial
    begin
        holds_done = 0;
        char_chan.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (holds_asked != holds_done)
            begin
                holds_done++;
                char_chan.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                char_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Run stopped: the encoder did not finish in time.");
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset once, directed messages, then three random phases with
    // different idle patterns, the last one starting with a long receiver hold-off.
    initial
    begin
        int pos;
        int target;
        pos = 0;
        holds_asked = 0;
        bytes_sent = 0;
        msgs_sent = 0;
        source_idle_pct = 22;
        sink_idle_pct = 56;
        rst_n <= 1'b0;
        byte_chan.valid     <= 1'b0;
        byte_chan.byte_in   <= 8'h00;
        byte_chan.last_byte <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int m = 0; m < DIRECTED_MSGS; m++)
        begin
            for (int i = 0; i < DIRECTED_LENS[m]; i++)
            begin
                send_byte(DIRECTED_BYTES[pos], i == DIRECTED_LENS[m] - 1);
                pos++;
            end
            msgs_sent++;
        end

        // Phase one: the sender idles now and then, the receiver more than half the time.
        target = bytes_sent + ITEMS_PER_PHASE;
        while (bytes_sent < target)
        begin
            send_message(pick_length());
        end

        // Phase two: the roles swap, so the block mostly waits for input.
        source_idle_pct = 56;
        sink_idle_pct = 22;
        target = bytes_sent + ITEMS_PER_PHASE;
        while (bytes_sent < target)
        begin
            send_message(pick_length());
        end

        // Phase three: no idling at all. It opens with a long message sent while the
        // receiver is held off, which backs the queue up until byte requests stall.
        source_idle_pct = 0;
        sink_idle_pct = 0;
        holds_asked++;
        send_message(40);
        target = bytes_sent + ITEMS_PER_PHASE - 40;
        while (bytes_sent < target)
        begin
            send_message(pick_length());
        end

        byte_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d bytes in %0d messages; %0d characters and %0d message ends checked.",
                 bytes_sent, msgs_sent, chars_checked, msgs_closed);
        $display("Idle patterns: slow receiver, slow sender, none, with one long output stall.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
